// ----- src/tensor_pad_source_address_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tensor pad source address block
// Shared shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef TENSOR_PAD_SOURCE_ADDRESS_TOP_ASSERT_SVH
`define TENSOR_PAD_SOURCE_ADDRESS_TOP_ASSERT_SVH

// same-cycle implication, held off while reset is high
`define TPSA_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, also checked through reset
`define TPSA_ASSERT_NEXT(name, clk, ante, cons, msg) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

// implication after a fixed number of cycles
`define TPSA_ASSERT_LATENCY(name, clk, rst, ante, cons, lat, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##lat (cons)) \
      else $error(msg);

`endif

// ----- src/tpsa_pkg.sv -----
// ----------------------------------------------------------------------------
// tpsa_pkg
// Widths, codes and stage types shared by the pad source address pipeline.
// ----------------------------------------------------------------------------
package tpsa_pkg;

   localparam int COORD_BITS    = 16;              // significant coordinate bits
   localparam int RANK          = 4;               // active dimensions, outermost first
   localparam int NUM_DIMS      = 4;
   localparam int SLOT_BITS     = 16;              // packed slot and field width
   localparam int DIFF_BITS     = SLOT_BITS + 2;   // coordinate minus front pad
   localparam int WIDE_BITS     = SLOT_BITS + 3;   // mapped and extent arithmetic
   localparam int OFFSET_BITS   = 64;
   localparam int ACC1_BITS     = 2 * COORD_BITS;  // partial offset after dimension one
   localparam int ACC2_BITS     = 3 * COORD_BITS;  // partial offset after dimension two
   localparam int ACC3_BITS     = 4 * COORD_BITS;  // full offset
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_ADDR_LSB  = 3;
   localparam int PIPE_LATENCY  = 5;

   localparam logic [CSR_DATA_BITS-1:0] SOURCE_EXTENTS_RESET = 64'h0001_0001_0001_0001;

   typedef enum logic [1:0] {
      MODE_CONSTANT  = 2'd0,
      MODE_EDGE      = 2'd1,
      MODE_REFLECT   = 2'd2,
      MODE_SYMMETRIC = 2'd3
   } pad_mode_type;

   typedef enum logic [1:0] {
      REG_PAD_MODE       = 2'd0,
      REG_SOURCE_EXTENTS = 2'd1,
      REG_FRONT_PADS     = 2'd2,
      REG_BACK_PADS      = 2'd3
   } reg_index_type;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef coord_type [NUM_DIMS-1:0] coord_vec_type;
   typedef logic [SLOT_BITS-1:0] slot_type;
   typedef slot_type [NUM_DIMS-1:0] slot_vec_type;
   typedef logic [DIFF_BITS-1:0] diff_type;
   typedef diff_type [NUM_DIMS-1:0] diff_vec_type;

   typedef struct packed {
      pad_mode_type  mode;
      coord_vec_type ext;
      slot_vec_type  front_pad;
      slot_vec_type  back_pad;
   } pad_cfg_type;

   typedef struct packed {
      logic                valid;
      diff_vec_type        diff;
      logic [NUM_DIMS-1:0] front;
      logic [NUM_DIMS-1:0] back;
      logic                empty_src;
      logic                empty_out;
      logic                out_oor;
   } class_stage_type;

   typedef struct packed {
      logic          valid;
      coord_vec_type src;
      logic          fill;
      logic          oor;
   } map_stage_type;

   typedef struct packed {
      logic                   valid;
      coord_vec_type          src;
      logic                   fill;
      logic                   oor;
      logic [OFFSET_BITS-1:0] offset;
   } result_type;

endpackage

// ----- src/tpsa_classify.sv -----
// ----------------------------------------------------------------------------
// tpsa_classify
// First stage: output extents, range flags and front/body/back class per dim.
// ----------------------------------------------------------------------------
module tpsa_classify import tpsa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  pad_cfg_type     cfg,
   input  coord_vec_type   coord,
   output class_stage_type stage_ff
);

   class_stage_type stage_in;

   always_comb begin
      logic signed [WIDE_BITS-1:0] ext_w;
      logic signed [WIDE_BITS-1:0] fp_w;
      logic signed [WIDE_BITS-1:0] bp_w;
      logic signed [WIDE_BITS-1:0] oext_w;
      logic signed [WIDE_BITS-1:0] crd_w;
      logic signed [WIDE_BITS-1:0] diff_w;
      stage_in = '0;
      stage_in.valid = accept;
      for (int d = 0; d < NUM_DIMS; d++) begin
         ext_w  = $signed(WIDE_BITS'(cfg.ext[d]));
         fp_w   = WIDE_BITS'($signed(cfg.front_pad[d]));
         bp_w   = WIDE_BITS'($signed(cfg.back_pad[d]));
         oext_w = ext_w + fp_w + bp_w;
         crd_w  = $signed(WIDE_BITS'(coord[d]));
         diff_w = crd_w - fp_w;
         stage_in.diff[d]  = diff_w[DIFF_BITS-1:0];
         stage_in.front[d] = diff_w[WIDE_BITS-1];
         stage_in.back[d]  = !diff_w[WIDE_BITS-1] && (diff_w >= ext_w);
         if (d < RANK) begin
            if (cfg.ext[d] == '0) stage_in.empty_src = 1'b1;
            if (oext_w[WIDE_BITS-1] || (oext_w == '0)) stage_in.empty_out = 1'b1;
            if (crd_w >= oext_w) stage_in.out_oor = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

endmodule

// ----- src/tpsa_map.sv -----
// ----------------------------------------------------------------------------
// tpsa_map
// Second stage: source coordinate per dim under the pad mode, fill and range.
// ----------------------------------------------------------------------------
module tpsa_map import tpsa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  pad_cfg_type     cfg,
   input  class_stage_type class_ff,
   output map_stage_type   stage_ff
);

   map_stage_type stage_in;

   always_comb begin
      logic signed [WIDE_BITS-1:0] s_w;
      logic signed [WIDE_BITS-1:0] t_w;
      logic signed [WIDE_BITS-1:0] sym_w;
      logic signed [WIDE_BITS-1:0] m_w;
      logic [NUM_DIMS-1:0]         pad_fill;
      logic [NUM_DIMS-1:0]         map_oor;
      logic                        empty_fill;
      coord_vec_type               src_raw;
      pad_fill = '0;
      map_oor  = '0;
      src_raw  = '0;
      sym_w    = (cfg.mode == MODE_SYMMETRIC) ? WIDE_BITS'(1) : '0;
      for (int d = 0; d < NUM_DIMS; d++) begin
         s_w = $signed(WIDE_BITS'(cfg.ext[d]));
         t_w = WIDE_BITS'($signed(class_ff.diff[d]));
         m_w = t_w;
         if (class_ff.front[d] || class_ff.back[d]) begin
            case (cfg.mode)
               MODE_CONSTANT: begin
                  m_w = '0;
                  pad_fill[d] = (d < RANK);
               end
               MODE_EDGE: begin
                  m_w = class_ff.front[d] ? '0 : s_w - WIDE_BITS'(1);
               end
               MODE_REFLECT, MODE_SYMMETRIC: begin
                  // mirror about the border; symmetric repeats the border element
                  if (class_ff.front[d]) begin
                     m_w = -t_w - sym_w;
                  end else begin
                     m_w = (s_w <<< 1) - WIDE_BITS'(2) + sym_w - t_w;
                  end
               end
               default: begin
                  m_w = '0;
               end
            endcase
         end
         if (d < RANK) begin
            map_oor[d] = m_w[WIDE_BITS-1] || (m_w >= s_w);
            src_raw[d] = map_oor[d] ? '0 : m_w[COORD_BITS-1:0];
         end
      end
      empty_fill     = class_ff.empty_src && !class_ff.empty_out;
      stage_in.valid = class_ff.valid;
      stage_in.fill  = empty_fill || (|pad_fill);
      stage_in.oor   = class_ff.out_oor || (!empty_fill && (|map_oor));
      stage_in.src   = stage_in.fill ? '0 : src_raw;
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

endmodule

// ----- src/tpsa_offset.sv -----
// ----------------------------------------------------------------------------
// tpsa_offset
// Last three stages: row-major source offset, one multiply-add per stage.
// ----------------------------------------------------------------------------
module tpsa_offset import tpsa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  pad_cfg_type   cfg,
   input  map_stage_type map_ff,
   output result_type    result_ff
);

   typedef struct packed {
      logic                 valid;
      coord_vec_type        src;
      logic                 fill;
      logic                 oor;
      logic [ACC1_BITS-1:0] acc;
   } acc1_stage_type;

   typedef struct packed {
      logic                 valid;
      coord_vec_type        src;
      logic                 fill;
      logic                 oor;
      logic [ACC2_BITS-1:0] acc;
   } acc2_stage_type;

   coord_vec_type  factor;
   acc1_stage_type acc1_in, acc1_ff;
   acc2_stage_type acc2_in, acc2_ff;
   result_type     result_in;
   logic [ACC3_BITS-1:0] acc3;

   // inner dims outside the rank scale by one and add nothing
   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         factor[d] = (d < RANK) ? cfg.ext[d] : COORD_BITS'(1);
      end
   end

   always_comb begin
      acc1_in.valid = map_ff.valid;
      acc1_in.src   = map_ff.src;
      acc1_in.fill  = map_ff.fill;
      acc1_in.oor   = map_ff.oor;
      acc1_in.acc   = ACC1_BITS'(map_ff.src[0]) * ACC1_BITS'(factor[1])
                    + ACC1_BITS'(map_ff.src[1]);
   end

   always_comb begin
      acc2_in.valid = acc1_ff.valid;
      acc2_in.src   = acc1_ff.src;
      acc2_in.fill  = acc1_ff.fill;
      acc2_in.oor   = acc1_ff.oor;
      acc2_in.acc   = ACC2_BITS'(acc1_ff.acc) * ACC2_BITS'(factor[2])
                    + ACC2_BITS'(acc1_ff.src[2]);
   end

   always_comb begin
      acc3 = ACC3_BITS'(acc2_ff.acc) * ACC3_BITS'(factor[3])
           + ACC3_BITS'(acc2_ff.src[3]);
      result_in.valid  = acc2_ff.valid;
      result_in.src    = acc2_ff.src;
      result_in.fill   = acc2_ff.fill;
      result_in.oor    = acc2_ff.oor;
      result_in.offset = OFFSET_BITS'(acc3);
   end

   always_ff @(posedge clock) begin
      acc1_ff   <= acc1_in;
      acc2_ff   <= acc2_in;
      result_ff <= result_in;
      if (reset) begin
         acc1_ff.valid   <= 1'b0;
         acc2_ff.valid   <= 1'b0;
         result_ff.valid <= 1'b0;
      end
   end

endmodule

// ----- src/tensor_pad_source_address_top.sv -----
// ----------------------------------------------------------------------------
// tensor_pad_source_address_top
// Source address generator for padding a 4-D tensor.
// ----------------------------------------------------------------------------
// Give one padded-output coordinate per cycle on req_out_coord_0..3 with start;
// busy is never raised, so a new item is taken at every clock edge. Each item
// yields one result once it has passed every stage, shown on the rsp_ ports for
// a single cycle while rsp_valid is high; the receiver cannot hold it off, so
// it must capture it then. The five stages are: pad class and output range,
// mode mapping and fill/range flags, then one multiply-add per stage for the
// row-major offset (the three multipliers set the stage count). Write the
// mode, extents and pads over the APB port only while no item is in flight.
// ----------------------------------------------------------------------------
module tensor_pad_source_address_top import tpsa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [SLOT_BITS-1:0]     req_out_coord_0,
   input  logic [SLOT_BITS-1:0]     req_out_coord_1,
   input  logic [SLOT_BITS-1:0]     req_out_coord_2,
   input  logic [SLOT_BITS-1:0]     req_out_coord_3,
   output logic                     rsp_valid,
   output logic [SLOT_BITS-1:0]     rsp_src_coord_0,
   output logic [SLOT_BITS-1:0]     rsp_src_coord_1,
   output logic [SLOT_BITS-1:0]     rsp_src_coord_2,
   output logic [SLOT_BITS-1:0]     rsp_src_coord_3,
   output logic [OFFSET_BITS-1:0]   rsp_source_offset,
   output logic                     rsp_use_fill,
   output logic                     rsp_out_of_range,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   pad_mode_type             pad_mode_ff;
   logic [CSR_DATA_BITS-1:0] source_extents_ff;
   logic [CSR_DATA_BITS-1:0] front_pads_ff;
   logic [CSR_DATA_BITS-1:0] back_pads_ff;
   reg_index_type            reg_index;
   logic                     csr_write;

   pad_cfg_type     cfg;
   coord_vec_type   coord;
   class_stage_type class_ff;
   map_stage_type   map_ff;
   result_type      result_ff;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign reg_index = reg_index_type'(paddr[CSR_ADDR_BITS-1:CSR_ADDR_LSB]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_mode_ff       <= MODE_CONSTANT;
         source_extents_ff <= SOURCE_EXTENTS_RESET;
         front_pads_ff     <= '0;
         back_pads_ff      <= '0;
      end else if (csr_write) begin
         case (reg_index)
            REG_PAD_MODE:       pad_mode_ff       <= pad_mode_type'(pwdata[1:0]);
            REG_SOURCE_EXTENTS: source_extents_ff <= pwdata;
            REG_FRONT_PADS:     front_pads_ff     <= pwdata;
            REG_BACK_PADS:      back_pads_ff      <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_PAD_MODE:       prdata = CSR_DATA_BITS'(pad_mode_ff);
         REG_SOURCE_EXTENTS: prdata = source_extents_ff;
         REG_FRONT_PADS:     prdata = front_pads_ff;
         REG_BACK_PADS:      prdata = back_pads_ff;
         default:            prdata = '0;
      endcase
   end

   // dimension 0 sits in the top slot of each packed register
   always_comb begin
      cfg.mode = pad_mode_ff;
      for (int d = 0; d < NUM_DIMS; d++) begin
         cfg.ext[d] = source_extents_ff[SLOT_BITS*(NUM_DIMS-1-d) +: COORD_BITS];
         cfg.front_pad[d] = front_pads_ff[SLOT_BITS*(NUM_DIMS-1-d) +: SLOT_BITS];
         cfg.back_pad[d]  = back_pads_ff[SLOT_BITS*(NUM_DIMS-1-d) +: SLOT_BITS];
      end
      coord[0] = req_out_coord_0[COORD_BITS-1:0];
      coord[1] = req_out_coord_1[COORD_BITS-1:0];
      coord[2] = req_out_coord_2[COORD_BITS-1:0];
      coord[3] = req_out_coord_3[COORD_BITS-1:0];
   end

   tpsa_classify u_classify (
      .clock    (clock),
      .reset    (reset),
      .accept   (start && !busy),
      .cfg      (cfg),
      .coord    (coord),
      .stage_ff (class_ff)
   );

   tpsa_map u_map (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .class_ff (class_ff),
      .stage_ff (map_ff)
   );

   tpsa_offset u_offset (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .map_ff    (map_ff),
      .result_ff (result_ff)
   );

   assign rsp_valid         = result_ff.valid;
   assign rsp_src_coord_0   = SLOT_BITS'(result_ff.src[0]);
   assign rsp_src_coord_1   = SLOT_BITS'(result_ff.src[1]);
   assign rsp_src_coord_2   = SLOT_BITS'(result_ff.src[2]);
   assign rsp_src_coord_3   = SLOT_BITS'(result_ff.src[3]);
   assign rsp_source_offset = result_ff.offset;
   assign rsp_use_fill      = result_ff.fill;
   assign rsp_out_of_range  = result_ff.oor;

endmodule

// ----- src/tpsa_port_check.sv -----
// ----------------------------------------------------------------------------
// tpsa_port_check
// Port-level checks on item latency and fill results, bound to the top level.
// ----------------------------------------------------------------------------
`include "tensor_pad_source_address_top_assert.svh"

module tpsa_port_check import tpsa_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic [SLOT_BITS-1:0]   rsp_src_coord_0,
   input logic [SLOT_BITS-1:0]   rsp_src_coord_1,
   input logic [SLOT_BITS-1:0]   rsp_src_coord_2,
   input logic [SLOT_BITS-1:0]   rsp_src_coord_3,
   input logic [OFFSET_BITS-1:0] rsp_source_offset,
   input logic                   rsp_use_fill
);

   // every accepted item comes out after the fixed pipeline depth
   `TPSA_ASSERT_LATENCY(a_item_latency, clock, reset, start && !busy, rsp_valid, PIPE_LATENCY, "accepted item gave no result at pipeline depth")

   // no result without an item taken the pipeline depth before
   `TPSA_ASSERT_IMPLY(a_no_invented, clock, reset, rsp_valid, $past(start && !busy, PIPE_LATENCY), "result without a matching accepted item")

   // fill results carry a zero address
   `TPSA_ASSERT_IMPLY(a_fill_zero, clock, reset, rsp_valid && rsp_use_fill, (rsp_source_offset == '0) && (rsp_src_coord_0 == '0) && (rsp_src_coord_1 == '0) && (rsp_src_coord_2 == '0) && (rsp_src_coord_3 == '0), "fill result with nonzero source address")

   // reset drains the pipeline
   `TPSA_ASSERT_NEXT(a_reset_flush, clock, reset, !rsp_valid, "result strobe right after reset")

endmodule

bind tensor_pad_source_address_top tpsa_port_check u_port_check (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives padded-output coordinates into the pad source address block and
// checks each mapped source coordinate, offset, fill flag and range flag
// against an in-bench predictor or a typed expectation. The block is reconfigured
// through its APB port between phases of directed and random items.
// ----------------------------------------------------------------------------
module tb_top;
   import tpsa_pkg::*;

   localparam int CLK_PERIOD   = 20;
   localparam int STALL_LIMIT  = 2000;
   localparam int RAND_PHASES  = 12;
   localparam int PHASE_ITEMS  = 62;
   localparam logic [15:0] CRD_MASK = 16'((1 << COORD_BITS) - 1);

   // dimension 0 sits in the highest 16 bits, as in the registers
   typedef logic [0:NUM_DIMS-1][15:0] coord4_type;

   typedef struct packed {
      coord4_type  src;
      logic [63:0] offset;
      logic        fill;
      logic        oor;
   } src_addr_type;

   typedef struct packed {
      logic          is_cfg;
      reg_index_type idx;
      logic [63:0]   value;
      coord4_type    crd;
      logic          typed;
      src_addr_type  want;
   } pad_case_type;

   localparam src_addr_type AT_ORIGIN = '0;
   localparam src_addr_type FILL_ONLY = '{src: '0, offset: '0, fill: 1'b1, oor: 1'b0};
   localparam src_addr_type FILL_OOR  = '{src: '0, offset: '0, fill: 1'b1, oor: 1'b1};

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [SLOT_BITS-1:0]     req_out_coord_0 = '0;
   logic [SLOT_BITS-1:0]     req_out_coord_1 = '0;
   logic [SLOT_BITS-1:0]     req_out_coord_2 = '0;
   logic [SLOT_BITS-1:0]     req_out_coord_3 = '0;
   logic                     rsp_valid;
   logic [SLOT_BITS-1:0]     rsp_src_coord_0;
   logic [SLOT_BITS-1:0]     rsp_src_coord_1;
   logic [SLOT_BITS-1:0]     rsp_src_coord_2;
   logic [SLOT_BITS-1:0]     rsp_src_coord_3;
   logic [OFFSET_BITS-1:0]   rsp_source_offset;
   logic                     rsp_use_fill;
   logic                     rsp_out_of_range;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // predictor copy of the registers
   pad_mode_type cfg_mode    = MODE_CONSTANT;
   coord4_type   cfg_extents = SOURCE_EXTENTS_RESET;
   coord4_type   cfg_front   = '0;
   coord4_type   cfg_back    = '0;

   src_addr_type expected_addresses [$];
   pad_case_type pad_cases [$];
   int           mismatch_count = 0;
   int           quiet_cycles = 0;
   bit           pace_items = 1'b1;

   tensor_pad_source_address_top dut (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic src_addr_type predict_source_address(input coord4_type crd_in);
      longint ext [NUM_DIMS];
      longint lead [NUM_DIMS];
      longint span [NUM_DIMS];
      longint pos [NUM_DIMS];
      longint i, s, b, m, sym;
      logic [63:0] stride;
      logic front, back, empty_src, empty_out;
      src_addr_type r;
      r = '0;
      empty_src = 1'b0;
      empty_out = 1'b0;
      for (int d = 0; d < NUM_DIMS; d++) begin
         ext[d]  = longint'(cfg_extents[d] & CRD_MASK);
         lead[d] = longint'($signed(cfg_front[d]));
         span[d] = ext[d] + lead[d] + longint'($signed(cfg_back[d]));
         pos[d]  = longint'(crd_in[d] & CRD_MASK);
      end
      for (int d = 0; d < RANK; d++) begin
         if (ext[d] == 0) empty_src = 1'b1;
         if (span[d] <= 0) empty_out = 1'b1;
         if (pos[d] >= span[d]) r.oor = 1'b1;
      end
      if (empty_src && !empty_out) begin
         r.fill = 1'b1;
      end else begin
         for (int d = 0; d < RANK; d++) begin
            i = pos[d];
            s = ext[d];
            b = lead[d];
            front = (i < b);
            back = !front && (i >= b + s);
            if (!front && !back) begin
               m = i - b;
            end else if (cfg_mode == MODE_CONSTANT) begin
               r.fill = 1'b1;
               m = 0;
            end else if (cfg_mode == MODE_EDGE) begin
               m = front ? 0 : s - 1;
            end else begin
               // symmetric repeats the border element, reflect does not
               sym = (cfg_mode == MODE_SYMMETRIC) ? 1 : 0;
               m = front ? b - i - sym : 2 * s + b - 2 + sym - i;
            end
            if (m < 0 || m >= s) begin
               r.oor = 1'b1;
               m = 0;
            end
            r.src[d] = m[15:0];
         end
      end
      if (r.fill) r.src = '0;
      stride = 64'd1;
      for (int d = RANK - 1; d >= 0; d--) begin
         r.offset = r.offset + {48'd0, r.src[d]} * stride;
         stride = stride * {48'd0, 16'(ext[d])};
      end
      return r;
   endfunction

   function automatic void add_setting(input reg_index_type idx, input logic [63:0] value);
      pad_case_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.idx = idx;
      row.value = value;
      pad_cases.insert(pad_cases.size(), row);
   endfunction

   function automatic void add_item(input coord4_type crd, input logic typed,
                                    input src_addr_type want);
      pad_case_type row;
      row = '0;
      row.crd = crd;
      row.typed = typed;
      row.want = want;
      pad_cases.insert(pad_cases.size(), row);
   endfunction

   task automatic write_setting(input reg_index_type idx, input logic [63:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CSR_ADDR_BITS'(idx) << CSR_ADDR_LSB;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_PAD_MODE:       cfg_mode = pad_mode_type'(value[1:0]);
         REG_SOURCE_EXTENTS: cfg_extents = value;
         REG_FRONT_PADS:     cfg_front = value;
         REG_BACK_PADS:      cfg_back = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_item(input coord4_type crd, input logic typed,
                            input src_addr_type want);
      int gap;
      gap = pace_items ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_out_coord_0 <= crd[0];
      req_out_coord_1 <= crd[1];
      req_out_coord_2 <= crd[2];
      req_out_coord_3 <= crd[3];
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      expected_addresses.insert(expected_addresses.size(),
                                typed ? want : predict_source_address(crd));
   endtask

   // hold off until every item in flight has come out
   task automatic settle_pipeline();
      start <= 1'b0;
      while (expected_addresses.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   always @(posedge clock) begin
      src_addr_type got, want;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         got.src = {rsp_src_coord_0, rsp_src_coord_1, rsp_src_coord_2, rsp_src_coord_3};
         got.offset = rsp_source_offset;
         got.fill = rsp_use_fill;
         got.oor = rsp_out_of_range;
         if (expected_addresses.size() == 0) begin
            $display("%0t: unexpected result src %h offset %h", $time, got.src, got.offset);
            mismatch_count++;
         end else begin
            want = expected_addresses.pop_front();
            if (got !== want) mismatch_count++;
            for (int d = 0; d < NUM_DIMS; d++) begin
               if (got.src[d] !== want.src[d])
                  $display("%0t: src_coord_%0d expected %h actual %h",
                           $time, d, want.src[d], got.src[d]);
            end
            if (got.offset !== want.offset)
               $display("%0t: source_offset expected %h actual %h",
                        $time, want.offset, got.offset);
            if (got.fill !== want.fill)
               $display("%0t: use_fill expected %b actual %b", $time, want.fill, got.fill);
            if (got.oor !== want.oor)
               $display("%0t: out_of_range expected %b actual %b", $time, want.oor, got.oor);
         end
      end
   end

   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[tensor_pad_source_address_top] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int phase, n, kind, hi;
      longint span;
      coord4_type crd, ext_v, front_v, back_v;
      logic [63:0] mode_word;

      // reset state: unit extents, no pads, constant mode
      add_item(64'h0000_0000_0000_0000, 1'b1, AT_ORIGIN);
      add_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, FILL_OOR);
      add_item(64'h0000_0000_0001_0000, 1'b1, FILL_OOR);

      add_setting(REG_SOURCE_EXTENTS, 64'h0004_0005_0006_0007);
      add_setting(REG_FRONT_PADS,     64'h0002_0001_0000_0003);
      add_setting(REG_BACK_PADS,      64'h0001_0002_0003_0000);
      add_item(64'h0002_0001_0000_0003, 1'b1, AT_ORIGIN);
      add_item(64'h0005_0005_0005_0009, 1'b0, '0);
      add_item(64'h0000_0000_0000_0000, 1'b0, '0);
      add_item(64'h0006_0007_0008_0009, 1'b0, '0);
      add_item(64'h0007_0008_0009_000A, 1'b0, '0);

      // upper bits of the mode word are don't-care
      add_setting(REG_PAD_MODE, 64'hFFFF_FFFF_FFFF_FFFD);
      add_item(64'h0000_0000_0000_0000, 1'b0, '0);
      add_item(64'h0006_0007_0008_0009, 1'b0, '0);

      add_setting(REG_PAD_MODE, 64'(MODE_REFLECT));
      add_item(64'h0000_0000_0000_0000, 1'b0, '0);
      add_item(64'h0006_0007_0008_0009, 1'b0, '0);
      add_item(64'h0001_0000_0000_0002, 1'b0, '0);

      add_setting(REG_PAD_MODE, 64'(MODE_SYMMETRIC));
      add_item(64'h0000_0000_0000_0000, 1'b0, '0);
      add_item(64'h0006_0007_0008_0009, 1'b0, '0);

      // empty source in dimension one, cropped dimension zero
      add_setting(REG_SOURCE_EXTENTS, 64'h0003_0000_0004_0005);
      add_setting(REG_FRONT_PADS,     64'hFFFE_0002_0000_0000);
      add_setting(REG_BACK_PADS,      64'h0000_0001_FFFF_0000);
      add_item(64'h0000_0002_0001_0004, 1'b1, FILL_ONLY);
      add_item(64'h0001_0000_0000_0000, 1'b0, '0);

      // empty output in edge mode: clamp falls outside the source
      add_setting(REG_PAD_MODE,       64'(MODE_EDGE));
      add_setting(REG_SOURCE_EXTENTS, 64'h0001_0001_0001_0000);
      add_setting(REG_FRONT_PADS,     64'h0);
      add_setting(REG_BACK_PADS,      64'h0);
      add_item(64'h0000_0000_0000_0000, 1'b0, '0);

      // negative pads crop; mirrored pad wider than the source
      add_setting(REG_PAD_MODE,       64'(MODE_REFLECT));
      add_setting(REG_SOURCE_EXTENTS, 64'h0002_0001_0001_0008);
      add_setting(REG_FRONT_PADS,     64'h0005_0000_0000_FFFD);
      add_setting(REG_BACK_PADS,      64'h0000_0000_0000_FFFE);
      add_item(64'h0000_0000_0000_0000, 1'b0, '0);
      add_item(64'h0006_0000_0000_0002, 1'b0, '0);
      add_item(64'h0007_0000_0000_0003, 1'b0, '0);

      add_setting(REG_PAD_MODE,       64'(MODE_SYMMETRIC));
      add_setting(REG_SOURCE_EXTENTS, 64'hFFFF_FFFF_FFFF_FFFF);
      add_setting(REG_FRONT_PADS,     64'h7FFF_8000_7FFF_8000);
      add_setting(REG_BACK_PADS,      64'h8000_7FFF_0000_FFFF);
      add_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
      add_item(64'h0000_0000_0000_0000, 1'b0, '0);
      add_setting(REG_FRONT_PADS,     64'h0);
      add_setting(REG_BACK_PADS,      64'h0);
      add_item(64'hFFFE_FFFE_FFFE_FFFE, 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (pad_cases[k]) begin
         if (pad_cases[k].is_cfg) begin
            settle_pipeline();
            write_setting(pad_cases[k].idx, pad_cases[k].value);
         end else begin
            send_item(pad_cases[k].crd, pad_cases[k].typed, pad_cases[k].want);
         end
      end

      for (phase = 0; phase < RAND_PHASES; phase++) begin
         kind = $urandom_range(0, 7);
         for (int d = 0; d < NUM_DIMS; d++) begin
            if (kind == 0) begin
               ext_v[d]   = 16'($urandom);
               front_v[d] = 16'($urandom);
               back_v[d]  = 16'($urandom);
            end else if (kind == 1) begin
               ext_v[d]   = 16'($urandom_range(200, 65535));
               front_v[d] = 16'(int'($urandom_range(0, 6)) - 3);
               back_v[d]  = 16'(int'($urandom_range(0, 6)) - 3);
            end else begin
               ext_v[d]   = ($urandom_range(0, 29) == 0) ? 16'd0 : 16'($urandom_range(1, 9));
               front_v[d] = 16'(int'($urandom_range(0, 13)) - 3);
               back_v[d]  = 16'(int'($urandom_range(0, 13)) - 3);
            end
         end
         mode_word = {$urandom, $urandom};
         mode_word[1:0] = pad_mode_type'(phase % 4);
         settle_pipeline();
         write_setting(REG_PAD_MODE, mode_word);
         write_setting(REG_SOURCE_EXTENTS, ext_v);
         write_setting(REG_FRONT_PADS, front_v);
         write_setting(REG_BACK_PADS, back_v);
         pace_items = ($urandom_range(0, 3) != 0);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // mostly just around the output extent, now and then anywhere
            for (int d = 0; d < NUM_DIMS; d++) begin
               span = longint'(cfg_extents[d]) + longint'($signed(cfg_front[d]))
                      + longint'($signed(cfg_back[d]));
               hi = (span <= 0) ? 2 : ((span >= 65535) ? 65535 : int'(span) + 1);
               crd[d] = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, hi));
            end
            send_item(crd, 1'b0, '0);
         end
      end

      settle_pipeline();
      if (mismatch_count == 0 && expected_addresses.size() == 0) begin
         $display("[tensor_pad_source_address_top] OK");
      end else begin
         $display("[tensor_pad_source_address_top] ERROR");
      end
      $finish;
   end

endmodule
